[hw/rtl/rla_pkg.sv]
`default_nettype none

package rla_pkg;

  localparam int unsigned RING_SIZE_DEF = 64;
  localparam int unsigned CMDQ_DEPTH    = 2;
  localparam int unsigned OUT_DEPTH     = 4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [1:0] {
    K_ECHO  = 2'd0,
    K_STORE = 2'd1,
    K_LINE  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       line;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/rla_front.sv]
`default_nettype none

module rla_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    in_rx_byte,
  output logic               cmd_valid,
  output rla_pkg::cmd_t      cmd,
  input  wire logic          cmd_full
);

  logic          fr_valid_r;
  logic          fr_valid_nxt;
  rla_pkg::cmd_t fr_cmd_r;
  rla_pkg::kind_t kind;
  logic          accept;
  logic          fwd;

  always_comb begin
    if (in_rx_byte == rla_pkg::CH_CR) begin
      kind = rla_pkg::K_ECHO;
    end else if (in_rx_byte == rla_pkg::CH_LF) begin
      kind = rla_pkg::K_LINE;
    end else begin
      kind = rla_pkg::K_STORE;
    end
  end

  assign full      = fr_valid_r & cmd_full;
  assign accept    = push & ~full;
  assign fwd       = fr_valid_r & ~cmd_full;
  assign cmd_valid = fr_valid_r;
  assign cmd       = fr_cmd_r;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (fwd) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd_r.kind <= kind;
      fr_cmd_r.data <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rla_cmdq.sv]
`default_nettype none

module rla_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  input  wire rla_pkg::cmd_t wr_cmd,
  output logic               wr_full,
  output logic               rd_valid,
  output rla_pkg::cmd_t      rd_cmd,
  input  wire logic          rd_pop
);

  localparam int unsigned DEPTH = rla_pkg::CMDQ_DEPTH;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rla_pkg::cmd_t    q_r [DEPTH];
  logic [IDX_W-1:0] wp_r, wp_nxt;
  logic [IDX_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
    idx_inc = (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_full  = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = q_r[rp_r];
  assign do_wr    = wr_valid & ~wr_full;
  assign do_rd    = rd_pop & rd_valid;

  always_comb begin
    wp_nxt  = do_wr ? idx_inc(wp_r) : wp_r;
    rp_nxt  = do_rd ? idx_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(do_wr) - CNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wp_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rla_back.sv]
`default_nettype none

module rla_back #(
  parameter int unsigned RING_SIZE = rla_pkg::RING_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire rla_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               empty,
  input  wire logic          pop,
  output rla_pkg::result_t   res
);

  localparam int unsigned PTR_W  = $clog2(RING_SIZE);
  localparam int unsigned ODEPTH = rla_pkg::OUT_DEPTH;
  localparam int unsigned OIDX_W = $clog2(ODEPTH);
  localparam int unsigned OCNT_W = $clog2(ODEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [PTR_W-1:0] rd_inc;

  logic [7:0]       mem [RING_SIZE];
  logic [7:0]       mem_q_r;
  logic             mem_we;
  logic             mem_re;

  // result stage ahead of the output queue
  logic             b_valid_r, b_valid_nxt;
  logic             b_mem_r, b_mem_nxt;
  logic [7:0]       b_byte_r, b_byte_nxt;
  logic             b_line_r, b_line_nxt;
  logic             b_last_r, b_last_nxt;
  rla_pkg::result_t b_res;

  rla_pkg::result_t  oq_r [ODEPTH];
  logic [OIDX_W-1:0] owp_r, orp_r;
  logic [OCNT_W-1:0] ocnt_r, ocnt_nxt;
  logic              o_pop;
  logic              credit;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(RING_SIZE - 1)) ? '0 : p + 1'b1;
  endfunction

  // room for the request in the result stage plus the one being made now
  assign credit = (ocnt_r + OCNT_W'(b_valid_r)) < OCNT_W'(ODEPTH);
  assign rd_inc = ptr_inc(rd_r);

  always_comb begin
    state_nxt   = state_r;
    wr_nxt      = wr_r;
    rd_nxt      = rd_r;
    cmd_pop     = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    b_valid_nxt = 1'b0;
    b_mem_nxt   = 1'b0;
    b_byte_nxt  = b_byte_r;
    b_line_nxt  = 1'b0;
    b_last_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && credit) begin
          cmd_pop     = 1'b1;
          b_valid_nxt = 1'b1;
          b_byte_nxt  = cmd.data;
          b_last_nxt  = 1'b1;
          case (cmd.kind)
            rla_pkg::K_STORE: begin
              mem_we = 1'b1;
              wr_nxt = ptr_inc(wr_r);
            end
            rla_pkg::K_LINE: begin
              if (rd_r != wr_r) begin
                b_last_nxt = 1'b0;
                state_nxt  = S_DRAIN;
              end
            end
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        if (credit) begin
          mem_re      = 1'b1;
          b_valid_nxt = 1'b1;
          b_mem_nxt   = 1'b1;
          b_line_nxt  = 1'b1;
          rd_nxt      = rd_inc;
          if (rd_inc == wr_r) begin
            b_last_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wr_r      <= '0;
      rd_r      <= '0;
      b_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_r      <= wr_nxt;
      rd_r      <= rd_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_mem_r  <= b_mem_nxt;
    b_byte_r <= b_byte_nxt;
    b_line_r <= b_line_nxt;
    b_last_r <= b_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_r] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= mem[rd_r];
    end
  end

  assign b_res.data = b_mem_r ? mem_q_r : b_byte_r;
  assign b_res.line = b_line_r;
  assign b_res.last = b_last_r;

  assign empty    = (ocnt_r == '0);
  assign o_pop    = pop & ~empty;
  assign res      = oq_r[orp_r];
  assign ocnt_nxt = ocnt_r + OCNT_W'(b_valid_r) - OCNT_W'(o_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (b_valid_r) begin
        owp_r <= owp_r + 1'b1;
      end
      if (o_pop) begin
        orp_r <= orp_r + 1'b1;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      oq_r[owp_r] <= b_res;
    end
  end

`ifndef ASSERT_OFF
  a_no_oq_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (ocnt_r < OCNT_W'(ODEPTH)))
    else $error("result queue written while full");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (rd_r != wr_r))
    else $error("drain with no pending bytes");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_r <= PTR_W'(RING_SIZE - 1)) && (wr_r <= PTR_W'(RING_SIZE - 1)))
    else $error("ring position out of range");

  a_wr_stable_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> $stable(wr_r))
    else $error("write position moved during drain");
`endif

endmodule

`default_nettype wire

[hw/rtl/rx_line_assembler_ring.sv]
// Serial receive line assembler kept in a ring buffer.
// Input side is a queue: present in_rx_byte with push; the byte is taken on
// a clock edge with push high and full low. Result side is a queue too:
// while empty is low, out_byte / out_is_line_char / out_last show the oldest
// result, which is taken on an edge with pop high.
// Every byte is echoed first (out_is_line_char = 0). Bytes other than CR and
// LF go into the ring. An LF releases the pending line bytes in order
// (out_is_line_char = 1); out_last marks the final result of each byte.
// An echo passes the front register, command queue, result stage and result
// queue before it shows. The back end gives one result per cycle while the
// result queue has room: one for a plain byte, one plus one per pending byte
// for an LF (at most RING_SIZE - 1 pending); the single ring read port paces the drain.
// A two-entry command queue between the classifier and the ring sequencer
// lets the input side keep taking bytes while a line drains.
// Reset (rst_n low, synchronous) empties all queues and sets both ring
// positions to zero; no clearing pass is needed.
// If pop stays low the result queue fills, the sequencer stops, the command
// queue fills and full rises; nothing is dropped.
`default_nettype none

module rx_line_assembler_ring #(
  parameter int unsigned RING_SIZE = rla_pkg::RING_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_rx_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_is_line_char,
  output logic            out_last
);

  logic             f_valid;
  rla_pkg::cmd_t    f_cmd;
  logic             q_full;
  logic             q_valid;
  rla_pkg::cmd_t    q_cmd;
  logic             q_pop;
  rla_pkg::result_t res;

  rla_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_rx_byte (in_rx_byte),
    .cmd_valid  (f_valid),
    .cmd        (f_cmd),
    .cmd_full   (q_full)
  );

  rla_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_cmd   (f_cmd),
    .wr_full  (q_full),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd),
    .rd_pop   (q_pop)
  );

  rla_back #(
    .RING_SIZE (RING_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign out_byte         = res.data;
  assign out_is_line_char = res.line;
  assign out_last         = res.last;

endmodule

`default_nettype wire
